// ===== rtl/core/gpsm_pkg.sv =====
package gpsm_pkg;

   // fixed field widths
   localparam int COORD_W  = 32;
   localparam int WEIGHT_W = 16;
   localparam int TOL_W    = 32;
   localparam int PASS_W   = 16;
   localparam int INDEX_W  = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // coordinate fraction bits; the datapath passes coordinates through unscaled
   localparam int COORD_FRAC_BITS = 16;

   // wide working width for products and rounded sums
   localparam int WIDE_W = 52;
   // summed change of one pass: up to 124 terms below 2^33
   localparam int CHG_W = 41;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_DATA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_SMOOTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PASSES    = 2'd3;

   // register reset values
   localparam logic [WEIGHT_W-1:0] WEIGHT_DATA_RST   = 16'd6554;
   localparam logic [WEIGHT_W-1:0] WEIGHT_SMOOTH_RST = 16'd22938;
   localparam logic [TOL_W-1:0]    TOLERANCE_RST     = 32'd66;
   localparam logic [PASS_W-1:0]   MAX_PASSES_RST    = 16'd1000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   localparam wide_type SAT_HI = wide_type'({1'b0, {(COORD_W-1){1'b1}}});
   localparam wide_type SAT_LO = -SAT_HI - wide_type'(1);

   // clamp a wide signed value to the coordinate range
   function automatic coord_type sat_coord(wide_type v);
      coord_type r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/gradient_path_smoother_unit.sv =====
// channel   | dir | handshake            | payload
// req       | in  | req_valid/req_ready  | point_x, point_y, last_point
// rsp       | out | rsp_valid/rsp_ready  | out_x, out_y, out_index, last_of_run, hit_cap,
//           |     |                      | overflowed
// csr       | in  | csr_write_en         | csr_index, csr_wdata
//
// points load at one request per cycle into the original and smoothed memories.
// a smoothing pass preloads the first two points, then each interior point runs read,
// multiply, add, multiply, add through the smoothed memory's single read port; a check ends the pass.
// emitting runs a memory read, an output load and a handshake for each point before the next one.
// reset is synchronous and clears control state only; memories are not cleared.
// req_ready is low from the last point until the final result is taken.
module gradient_path_smoother_unit #(
   parameter int MAX_POINTS      = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [gpsm_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [gpsm_pkg::COORD_W-1:0] req_point_y,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gpsm_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [gpsm_pkg::COORD_W-1:0] rsp_out_y,
   output logic [gpsm_pkg::INDEX_W-1:0]        rsp_out_index,
   output logic                                rsp_last_of_run,
   output logic                                rsp_hit_cap,
   output logic                                rsp_overflowed,
   input  logic                                csr_write_en,
   input  logic [gpsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import gpsm_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = 2 * COORD_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
   localparam wide_type HALF = wide_type'(1) <<< (WEIGHT_W - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_PRE0, S_PRE1, S_PRE2, S_RD, S_MUL1, S_ADD1,
      S_MUL2, S_ADD2, S_CHK, S_ERD, S_EOUT, S_EWAIT
   } state_type;

   // drop the weight fraction, round to nearest, halves up
   function automatic wide_type rnd(wide_type p);
      return (p + HALF) >>> WEIGHT_W;
   endfunction

   state_type          state_ff, state_in;
   logic [WEIGHT_W-1:0] wd_ff, wd_in, ws_ff, ws_in;
   logic [TOL_W-1:0]    tol_ff, tol_in;
   logic [PASS_W-1:0]   maxp_ff, maxp_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic [CHG_W-1:0]    change_ff, change_in;
   logic                hit_ff, hit_in;
   coord_type           prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type           cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type           next_x_ff, next_x_in, next_y_ff, next_y_in;
   coord_type           v1_x_ff, v1_x_in, v1_y_ff, v1_y_in;
   wide_type            p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic                rv_ff, rv_in;
   coord_type           rx_ff, rx_in, ry_ff, ry_in;
   logic [INDEX_W-1:0]  ridx_ff, ridx_in;
   logic                rlast_ff, rlast_in, rhit_ff, rhit_in, rovf_ff, rovf_in;

   // memory ports
   logic          orig_we, sm_we;
   logic [IW-1:0] orig_waddr, sm_waddr, orig_raddr, sm_raddr;
   logic [PW-1:0] orig_wdata, sm_wdata, orig_rdata, sm_rdata;

   // datapath terms
   coord_type            orig_x, orig_y, sm_x, sm_y, v2_x, v2_y;
   logic signed [32:0]   d1_x, d1_y, dc_x, dc_y;
   logic signed [34:0]   e_x, e_y;
   logic signed [49:0]   m1_x, m1_y;
   logic signed [51:0]   m2_x, m2_y;
   logic [PASS_W-1:0]    cap, pass_next;
   logic                 req_acc;

   gpsm_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_orig_ram (
      .clock   (clock),
      .wr_en   (orig_we),
      .wr_addr (orig_waddr),
      .wr_data (orig_wdata),
      .rd_addr (orig_raddr),
      .rd_data (orig_rdata)
   );

   gpsm_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_smooth_ram (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_waddr),
      .wr_data (sm_wdata),
      .rd_addr (sm_raddr),
      .rd_data (sm_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;

   assign orig_x = orig_rdata[COORD_W-1:0];
   assign orig_y = orig_rdata[PW-1:COORD_W];
   assign sm_x   = sm_rdata[COORD_W-1:0];
   assign sm_y   = sm_rdata[PW-1:COORD_W];

   // pull toward original point
   assign d1_x = $signed({orig_x[COORD_W-1], orig_x}) - $signed({cur_x_ff[COORD_W-1], cur_x_ff});
   assign d1_y = $signed({orig_y[COORD_W-1], orig_y}) - $signed({cur_y_ff[COORD_W-1], cur_y_ff});
   assign m1_x = $signed({1'b0, wd_ff}) * d1_x;
   assign m1_y = $signed({1'b0, wd_ff}) * d1_y;

   // pull toward neighbor midpoint
   assign e_x = 35'(prev_x_ff) + 35'(next_x_ff) - (35'(v1_x_ff) <<< 1);
   assign e_y = 35'(prev_y_ff) + 35'(next_y_ff) - (35'(v1_y_ff) <<< 1);
   assign m2_x = $signed({1'b0, ws_ff}) * e_x;
   assign m2_y = $signed({1'b0, ws_ff}) * e_y;

   assign v2_x = sat_coord(wide_type'(v1_x_ff) + rnd(p_x_ff));
   assign v2_y = sat_coord(wide_type'(v1_y_ff) + rnd(p_y_ff));

   // change of the point in this pass
   assign dc_x = 33'(cur_x_ff) - 33'(v2_x);
   assign dc_y = 33'(cur_y_ff) - 33'(v2_y);

   assign cap       = (maxp_ff == '0) ? PASS_W'(1) : maxp_ff;
   assign pass_next = pass_ff + PASS_W'(1);

   // memory addressing
   always_comb begin
      orig_we    = 1'b0;
      orig_waddr = count_ff[IW-1:0];
      orig_wdata = {req_point_y, req_point_x};
      orig_raddr = idx_ff;
      sm_we      = 1'b0;
      sm_waddr   = count_ff[IW-1:0];
      sm_wdata   = {req_point_y, req_point_x};
      sm_raddr   = idx_ff;
      if (req_acc && count_ff < MAX_CNT) begin
         orig_we = 1'b1;
         sm_we   = 1'b1;
      end
      case (state_ff)
         S_PRE0: sm_raddr = '0;
         S_PRE1: sm_raddr = IW'(1);
         S_RD:   sm_raddr = idx_ff + IW'(1);
         S_ADD2: begin
            sm_we    = 1'b1;
            sm_waddr = idx_ff;
            sm_wdata = {v2_y, v2_x};
         end
         default: ;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      wd_in     = wd_ff;
      ws_in     = ws_ff;
      tol_in    = tol_ff;
      maxp_in   = maxp_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      pass_in   = pass_ff;
      change_in = change_ff;
      hit_in    = hit_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      next_x_in = next_x_ff;
      next_y_in = next_y_ff;
      v1_x_in   = v1_x_ff;
      v1_y_in   = v1_y_ff;
      p_x_in    = p_x_ff;
      p_y_in    = p_y_ff;
      rv_in     = rv_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      ridx_in   = ridx_ff;
      rlast_in  = rlast_ff;
      rhit_in   = rhit_ff;
      rovf_in   = rovf_ff;

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_WEIGHT_DATA:   wd_in   = csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_SMOOTH: ws_in   = csr_wdata[WEIGHT_W-1:0];
            CSR_TOLERANCE:     tol_in  = csr_wdata[TOL_W-1:0];
            CSR_MAX_PASSES:    maxp_in = csr_wdata[PASS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (count_ff < MAX_CNT) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_point) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            idx_in  = '0;
            pass_in = '0;
            hit_in  = 1'b0;
            if (count_ff <= CW'(2)) begin
               state_in = S_ERD;
            end else begin
               state_in = S_PRE0;
            end
         end
         S_PRE0: state_in = S_PRE1;
         S_PRE1: begin
            prev_x_in = sm_x;
            prev_y_in = sm_y;
            state_in  = S_PRE2;
         end
         S_PRE2: begin
            cur_x_in  = sm_x;
            cur_y_in  = sm_y;
            idx_in    = IW'(1);
            change_in = '0;
            state_in  = S_RD;
         end
         S_RD: state_in = S_MUL1;
         S_MUL1: begin
            next_x_in = sm_x;
            next_y_in = sm_y;
            p_x_in    = wide_type'(m1_x);
            p_y_in    = wide_type'(m1_y);
            state_in  = S_ADD1;
         end
         S_ADD1: begin
            v1_x_in  = sat_coord(wide_type'(cur_x_ff) + rnd(p_x_ff));
            v1_y_in  = sat_coord(wide_type'(cur_y_ff) + rnd(p_y_ff));
            state_in = S_MUL2;
         end
         S_MUL2: begin
            p_x_in   = wide_type'(m2_x);
            p_y_in   = wide_type'(m2_y);
            state_in = S_ADD2;
         end
         S_ADD2: begin
            change_in = change_ff + CHG_W'(dc_x < 0 ? -dc_x : dc_x)
                                  + CHG_W'(dc_y < 0 ? -dc_y : dc_y);
            prev_x_in = v2_x;
            prev_y_in = v2_y;
            cur_x_in  = next_x_ff;
            cur_y_in  = next_y_ff;
            if ({1'b0, idx_ff} + (IW+1)'(2) == (IW+1)'(count_ff)) begin
               state_in = S_CHK;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_RD;
            end
         end
         S_CHK: begin
            pass_in = pass_next;
            idx_in  = '0;
            if (change_ff < CHG_W'(tol_ff)) begin
               hit_in   = 1'b0;
               state_in = S_ERD;
            end else if (pass_next >= cap) begin
               hit_in   = 1'b1;
               state_in = S_ERD;
            end else begin
               state_in = S_PRE0;
            end
         end
         S_ERD: state_in = S_EOUT;
         S_EOUT: begin
            rv_in    = 1'b1;
            rx_in    = sm_x;
            ry_in    = sm_y;
            ridx_in  = INDEX_W'(idx_ff);
            rlast_in = ({1'b0, idx_ff} + (IW+1)'(1) == (IW+1)'(count_ff));
            rhit_in  = hit_ff;
            rovf_in  = ovf_ff;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (rsp_ready) begin
               rv_in = 1'b0;
               if (rlast_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wd_ff    <= WEIGHT_DATA_RST;
         ws_ff    <= WEIGHT_SMOOTH_RST;
         tol_ff   <= TOLERANCE_RST;
         maxp_ff  <= MAX_PASSES_RST;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wd_ff    <= wd_in;
         ws_ff    <= ws_in;
         tol_ff   <= tol_in;
         maxp_ff  <= maxp_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
      idx_ff    <= idx_in;
      pass_ff   <= pass_in;
      change_ff <= change_in;
      hit_ff    <= hit_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      next_x_ff <= next_x_in;
      next_y_ff <= next_y_in;
      v1_x_ff   <= v1_x_in;
      v1_y_ff   <= v1_y_in;
      p_x_ff    <= p_x_in;
      p_y_ff    <= p_y_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      ridx_ff   <= ridx_in;
      rlast_ff  <= rlast_in;
      rhit_ff   <= rhit_in;
      rovf_ff   <= rovf_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_x       = rx_ff;
   assign rsp_out_y       = ry_ff;
   assign rsp_out_index   = ridx_ff;
   assign rsp_last_of_run = rlast_ff;
   assign rsp_hit_cap     = rhit_ff;
   assign rsp_overflowed  = rovf_ff;

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a result is pending");

   // the final result returns the block to loading
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run) |=> req_ready)
      else $error("block not idle after final result");

   // stored point count stays within capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("point count beyond capacity");

endmodule

// ===== rtl/core/gpsm_ram.sv =====
module gpsm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gpsm_pkg::*;

   typedef struct {
      coord_type          x;
      coord_type          y;
      logic [INDEX_W-1:0] index;
      logic               last;
      logic               cap_hit;
      logic               ovf;
   } path_point_type;

   // smoothing predictor and expected point store
   class smoother_scoreboard;
      bit [WEIGHT_W-1:0] w_data;
      bit [WEIGHT_W-1:0] w_smooth;
      bit [TOL_W-1:0]    tol;
      bit [PASS_W-1:0]   pass_cap;
      int                orig_x[64];
      int                orig_y[64];
      int                sm_x[64];
      int                sm_y[64];
      int                count;
      bit                ovf;
      path_point_type    expected_points[$];
      int                mismatches;
      int                points_checked;
      int                paths_done;
      int                capped_paths;
      int                overflow_paths;

      function new();
         w_data   = WEIGHT_DATA_RST;
         w_smooth = WEIGHT_SMOOTH_RST;
         tol      = TOLERANCE_RST;
         pass_cap = MAX_PASSES_RST;
         count    = 0;
         ovf      = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_WEIGHT_DATA:   w_data   = v[WEIGHT_W-1:0];
            CSR_WEIGHT_SMOOTH: w_smooth = v[WEIGHT_W-1:0];
            CSR_TOLERANCE:     tol      = v[TOL_W-1:0];
            CSR_MAX_PASSES:    pass_cap = v[PASS_W-1:0];
            default: ;
         endcase
      endfunction

      // weight times difference, rounded half up
      function longint scaled(longint w, longint d);
         longint p;
         p = w * d;
         return (p + 32768) >>> 16;
      endfunction

      function int clamp(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return int'(v);
      endfunction

      function int relax(int s, int o, int prev, int nxt);
         longint v;
         v = s;
         v = clamp(v + scaled(longint'(w_data), longint'(o) - v));
         v = clamp(v + scaled(longint'(w_smooth), longint'(prev) + longint'(nxt) - 2 * v));
         return int'(v);
      endfunction

      // gauss-seidel passes, returns 1 when the cap stopped them
      function bit run_passes(int n);
         int     limit;
         int     passes;
         longint change;
         int     ox;
         int     oy;
         limit  = (pass_cap == 0) ? 1 : pass_cap;
         passes = 0;
         if (n <= 2) return 0;
         do begin
            change = 0;
            for (int i = 1; i + 1 < n; i++) begin
               ox = sm_x[i];
               oy = sm_y[i];
               sm_x[i] = relax(ox, orig_x[i], sm_x[i-1], sm_x[i+1]);
               sm_y[i] = relax(oy, orig_y[i], sm_y[i-1], sm_y[i+1]);
               change += (longint'(ox) > longint'(sm_x[i])) ?
                         longint'(ox) - sm_x[i] : longint'(sm_x[i]) - ox;
               change += (longint'(oy) > longint'(sm_y[i])) ?
                         longint'(oy) - sm_y[i] : longint'(sm_y[i]) - oy;
            end
            passes++;
            if (change < longint'(tol)) return 0;
         end while (passes < limit);
         return 1;
      endfunction

      function void note_request(int x, int y, bit last);
         bit             capped;
         path_point_type p;
         if (count < 64) begin
            orig_x[count] = x;
            orig_y[count] = y;
            count++;
         end else begin
            ovf = 1;
         end
         if (!last) return;
         for (int k = 0; k < count; k++) begin
            sm_x[k] = orig_x[k];
            sm_y[k] = orig_y[k];
         end
         capped = run_passes(count);
         for (int k = 0; k < count; k++) begin
            p.x       = sm_x[k];
            p.y       = sm_y[k];
            p.index   = k[INDEX_W-1:0];
            p.last    = (k + 1 == count);
            p.cap_hit = capped;
            p.ovf     = ovf;
            expected_points.insert(expected_points.size(), p);
         end
         paths_done++;
         capped_paths += capped;
         overflow_paths += ovf;
         count = 0;
         ovf   = 0;
      endfunction

      function void check_result(path_point_type got);
         path_point_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point: index %0d x %0d y %0d", got.index, got.x, got.y);
            return;
         end
         want = expected_points.pop_front();
         points_checked++;
         if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
             got.last !== want.last || got.cap_hit !== want.cap_hit ||
             got.ovf !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("point mismatch: exp x %0d y %0d idx %0d last %0d cap %0d ovf %0d",
                        want.x, want.y, want.index, want.last, want.cap_hit, want.ovf);
               $display("                got x %0d y %0d idx %0d last %0d cap %0d ovf %0d",
                        got.x, got.y, got.index, got.last, got.cap_hit, got.ovf);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   coord_type             req_point_x;
   coord_type             req_point_y;
   logic                  req_last_point;
   logic                  rsp_valid;
   logic                  rsp_ready;
   coord_type             rsp_out_x;
   coord_type             rsp_out_y;
   logic [INDEX_W-1:0]    rsp_out_index;
   logic                  rsp_last_of_run;
   logic                  rsp_hit_cap;
   logic                  rsp_overflowed;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   smoother_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int requests_sent;

   gradient_path_smoother_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver ready, with random stalls and long hold-offs
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready = 0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // result check
   always @(posedge clock) begin
      path_point_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.x       = rsp_out_x;
         got.y       = rsp_out_y;
         got.index   = rsp_out_index;
         got.last    = rsp_last_of_run;
         got.cap_hit = rsp_hit_cap;
         got.ovf     = rsp_overflowed;
         sb.check_result(got);
      end
   end

   // one request, called at a falling edge
   task automatic send_point(int x, int y, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_point_x    = x;
      req_point_y    = y;
      req_last_point = last;
      req_valid      = 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(x, y, last);
      requests_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_write_en = 1;
      csr_index    = idx;
      csr_wdata    = v;
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_write_en = 0;
   endtask

   // wait for all expected points, then let the block settle
   task automatic drain();
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_all(int wd, int ws, int tl, int cap);
      drain();
      write_reg(CSR_WEIGHT_DATA, wd);
      write_reg(CSR_WEIGHT_SMOOTH, ws);
      write_reg(CSR_TOLERANCE, tl);
      write_reg(CSR_MAX_PASSES, cap);
   endtask

   function automatic int rand_coord(bit wide);
      int v;
      if (wide) begin
         v = $urandom;
      end else begin
         v = $urandom_range(2097151);
         v = v - 1048576;
      end
      return v;
   endfunction

   // a path of random points, mostly small coordinates
   task automatic send_path(int n);
      bit wide;
      wide = ($urandom_range(3) == 0);
      for (int i = 0; i < n; i++)
         send_point(rand_coord(wide), rand_coord(wide), i == n - 1);
   endtask

   function automatic int rand_length();
      int r;
      r = $urandom_range(99);
      if (r < 12) return $urandom_range(1, 2);
      if (r < 82) return $urandom_range(3, 8);
      if (r < 95) return $urandom_range(9, 40);
      return $urandom_range(64, 67);
   endfunction

   // random paths; with pressure the first loop always holds off the receiver
   task automatic random_segment(int items, bit pressure);
      int stop_at;
      int loops;
      stop_at = requests_sent + items;
      loops   = 0;
      while (requests_sent < stop_at) begin
         if ($urandom_range(3) == 0)
            set_all($urandom_range(65535), $urandom_range(65535),
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000),
                    $urandom_range(0, 12));
         if (pressure && (loops == 0 || $urandom_range(4) == 0)) begin
            hold_cycles = 400;
            send_path($urandom_range(3, 6));
         end
         send_path(rand_length());
         loops++;
      end
   endtask

   initial begin
      sb             = new();
      reset          = 1;
      req_valid      = 0;
      req_point_x    = 0;
      req_point_y    = 0;
      req_last_point = 0;
      csr_write_en   = 0;
      csr_index      = CSR_WEIGHT_DATA;
      csr_wdata      = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_cycles    = 0;
      requests_sent  = 0;
      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // short paths and extremes at reset settings
      send_point(32'sh7fffffff, 32'sh80000000, 1);
      send_point(32'sh80000000, 32'sh7fffffff, 0);
      send_point(0, -1, 1);
      send_point(32'sh7fffffff, 32'sh80000000, 0);
      send_point(32'sh80000000, 32'sh7fffffff, 0);
      send_point(32'sh7fffffff, 32'sh80000000, 1);
      send_point(0, 0, 0);
      send_point(65536, -65536, 0);
      send_point(131072, 0, 0);
      send_point(196608, 65536, 1);

      // zero weights, zero tolerance, zero cap
      set_all(0, 0, 0, 0);
      send_point(100, 200, 0);
      send_point(-300, 400, 0);
      send_point(500, -600, 1);

      // full weights, full tolerance, full cap, with saturation
      set_all(65535, 65535, 32'hffffffff, 65535);
      send_point(32'sh80000000, 32'sh7fffffff, 0);
      send_point(32'sh7fffffff, 32'sh80000000, 0);
      send_point(32'sh80000000, 32'sh7fffffff, 0);
      send_point(32'sh7fffffff, 32'sh80000000, 0);
      send_point(32'sh80000000, 32'sh7fffffff, 1);

      // zero tolerance runs to a small cap
      set_all(WEIGHT_DATA_RST, WEIGHT_SMOOTH_RST, 0, 3);
      send_path(5);

      // random paths under three idle patterns
      send_idle_pct = 6;
      recv_idle_pct = 50;
      random_segment(65, 1);
      send_idle_pct = 50;
      recv_idle_pct = 6;
      random_segment(65, 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_all(6554, 22938, 66, 1000);
      send_path(64);
      send_path(66);
      random_segment(65, 0);

      drain();
      $display("covered %0d paths (%0d capped, %0d overflowed) from %0d requests",
               sb.paths_done, sb.capped_paths, sb.overflow_paths, requests_sent);
      $display("checked %0d smoothed points, %0d mismatches",
               sb.points_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/gpsm_pkg.sv
rtl/core/gpsm_ram.sv
rtl/core/gradient_path_smoother_unit.sv
bench/testbench.sv
